>>> hw/rtl/sliding_window_event_counter_top_defines.svh
// Assertion macros for the sliding-window event counter.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef SLIDING_WINDOW_EVENT_COUNTER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_EVENT_COUNTER_TOP_DEFINES_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define SWEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, off during reset.
`define SWEC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/swec_pkg.sv
// Shared types and constants for the sliding-window event counter.
// No dependencies; used by swec_ram, swec_acc and the top level.
package swec_pkg;

  localparam int unsigned NUM_KEYS   = 16;
  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned KEY_W      = 4;
  localparam int unsigned SLOT_W     = $clog2(MAX_WINDOW);
  localparam int unsigned WIN_W      = 7;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned ADDR_W     = KEY_W + SLOT_W;
  localparam int unsigned DEPTH      = 2 ** ADDR_W;
  localparam int unsigned DATA_W     = 64;

  localparam logic [WIN_W-1:0] WinReset = WIN_W'(60);

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_TICK = 3'd2,
    OP_SUM  = 3'd3,
    OP_READ = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ACC_CLR,
    ACC_ADD,
    ACC_SUB,
    ACC_ACCUM,
    ACC_LOAD
  } acc_mode_e;

  typedef struct packed {
    logic      en;
    acc_mode_e mode;
  } acc_ctrl_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_RD,
    S_RMW,
    S_SUM_RD,
    S_SUM_ACC,
    S_TICK,
    S_OUT
  } state_e;

endpackage

>>> hw/rtl/swec_ram.sv
// Single-port bucket store with registered read data.
// Depends on swec_pkg for the address request struct and sizes.
module swec_ram (
  input  logic                        clk_i,
  input  swec_pkg::ram_req_t          req_i,
  input  logic [swec_pkg::DATA_W-1:0] wdata_i,
  output logic [swec_pkg::DATA_W-1:0] rdata_o
);

  logic [swec_pkg::DATA_W-1:0] mem_q [swec_pkg::DEPTH];
  logic [swec_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/swec_acc.sv
// Shared 64-bit add/subtract unit with its accumulator register.
// Depends on swec_pkg for the control struct and mode codes.
module swec_acc (
  input  logic                        clk_i,
  input  swec_pkg::acc_ctrl_t         ctrl_i,
  input  logic [swec_pkg::DATA_W-1:0] rdata_i,
  input  logic [swec_pkg::DATA_W-1:0] amount_i,
  output logic [swec_pkg::DATA_W-1:0] acc_o
);

  logic [swec_pkg::DATA_W-1:0] acc_q;
  logic [swec_pkg::DATA_W-1:0] acc_d;
  logic [swec_pkg::DATA_W-1:0] opa;
  logic [swec_pkg::DATA_W-1:0] opb;
  logic                        sub;
  logic [swec_pkg::DATA_W-1:0] sum;

  always_comb begin
    opa = rdata_i;
    opb = '0;
    sub = 1'b0;
    case (ctrl_i.mode)
      swec_pkg::ACC_ADD: begin
        opb = amount_i;
      end
      swec_pkg::ACC_SUB: begin
        opb = amount_i;
        sub = 1'b1;
      end
      swec_pkg::ACC_ACCUM: begin
        opa = acc_q;
        opb = rdata_i;
      end
      default: begin
        opb = '0;
      end
    endcase
  end

  // Subtract as add of the inverted operand plus one; wraps modulo 2^64.
  assign sum   = opa + (opb ^ {swec_pkg::DATA_W{sub}})
               + swec_pkg::DATA_W'(sub);
  assign acc_d = (ctrl_i.mode == swec_pkg::ACC_CLR) ? '0 : sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

>>> hw/rtl/sliding_window_event_counter_top.sv
// Sliding-window event counter: one ring of one-second buckets per key.
// Depends on swec_pkg, swec_ram, swec_acc and the assertion macro header.
//
// An item is taken when start_i is high and busy_o is low; its result, if any, shows on
// result_value_o and status_o for the single cycle in which done_o is high, and must be
// captured then, since the receiver cannot stall. Add, subtract and bucket read step
// through accept, store read, add/subtract (a load for a read) and write back (add and
// subtract only) with result; a window sum over N buckets reads them one by one, as the
// shared adder folds in one bucket for each read of the single store port; a tick clears
// one key's bucket per cycle, or nothing when the window is 1. An item that is rejected
// for range, or a sum of zero buckets, goes from accept straight to its result. After
// reset all 1024 store entries are cleared one entry per cycle with busy_o high. A write
// to window_len raises busy_o while the current slot is reduced into the new window by
// repeated subtraction.
`include "sliding_window_event_counter_top_defines.svh"

module sliding_window_event_counter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [2:0]                        op_i,
  input  logic [swec_pkg::KEY_W-1:0]        key_i,
  input  logic signed [swec_pkg::DATA_W-1:0] amount_i,
  input  logic [swec_pkg::CNT_W-1:0]        duration_i,
  input  logic [swec_pkg::SLOT_W-1:0]       slot_i,
  input  logic                              window_len_we_i,
  input  logic [swec_pkg::WIN_W-1:0]        window_len_wdata_i,
  output logic                              done_o,
  output logic signed [swec_pkg::DATA_W-1:0] result_value_o,
  output logic                              status_o
);

  swec_pkg::state_e              state_q, state_d;
  swec_pkg::op_e                 op_q, op_d;
  logic [swec_pkg::KEY_W-1:0]    key_q, key_d;
  logic [swec_pkg::SLOT_W-1:0]   ptr_q, ptr_d;
  logic [swec_pkg::SLOT_W-1:0]   cur_q, cur_d;
  logic [swec_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [swec_pkg::WIN_W-1:0]    window_q;
  logic                          status_q, status_d;
  logic                          mod_pend_q, mod_pend_d;
  logic [swec_pkg::DATA_W-1:0]   amt_q;
  logic                          load_amt;

  swec_pkg::ram_req_t            ram_req;
  logic [swec_pkg::DATA_W-1:0]   ram_wdata;
  logic [swec_pkg::DATA_W-1:0]   ram_rdata;
  swec_pkg::acc_ctrl_t           acc_ctrl;
  logic [swec_pkg::DATA_W-1:0]   acc_val;

  logic [swec_pkg::WIN_W-1:0]    win_eff;
  logic [swec_pkg::SLOT_W-1:0]   win_m1;
  logic [swec_pkg::WIN_W-1:0]    inc1;
  logic [swec_pkg::SLOT_W-1:0]   cur_new;
  logic [swec_pkg::WIN_W-1:0]    inc2;
  logic [swec_pkg::SLOT_W-1:0]   nxt_slot;
  logic [swec_pkg::SLOT_W-1:0]   sum_start;
  logic [swec_pkg::SLOT_W-1:0]   ptr_prev;
  logic [swec_pkg::CNT_W-1:0]    sum_count;
  logic                          key_bad;
  logic                          slot_bad;
  logic [swec_pkg::ADDR_W-1:0]   sweep_next;

  // Effective window: zero reads as one, above the maximum saturates.
  always_comb begin
    if (window_q == '0) begin
      win_eff = swec_pkg::WIN_W'(1);
    end else if (window_q > swec_pkg::WIN_W'(swec_pkg::MAX_WINDOW)) begin
      win_eff = swec_pkg::WIN_W'(swec_pkg::MAX_WINDOW);
    end else begin
      win_eff = window_q;
    end
  end

  assign win_m1    = swec_pkg::SLOT_W'(win_eff - swec_pkg::WIN_W'(1));
  assign inc1      = {1'b0, cur_q} + swec_pkg::WIN_W'(1);
  assign cur_new   = (inc1 == win_eff) ? '0 : swec_pkg::SLOT_W'(inc1);
  assign inc2      = {1'b0, cur_new} + swec_pkg::WIN_W'(1);
  assign nxt_slot  = (inc2 == win_eff) ? '0 : swec_pkg::SLOT_W'(inc2);
  assign sum_start = (cur_q == '0) ? win_m1 : cur_q - swec_pkg::SLOT_W'(1);
  assign ptr_prev  = (ptr_q == '0) ? win_m1 : ptr_q - swec_pkg::SLOT_W'(1);
  assign sum_count = (duration_i > win_eff) ? win_eff : duration_i;
  assign key_bad   = ({1'b0, key_i} >= (swec_pkg::KEY_W + 1)'(swec_pkg::NUM_KEYS));
  assign slot_bad  = ({1'b0, slot_i} >= win_eff);
  assign sweep_next = {key_q, ptr_q} + swec_pkg::ADDR_W'(1);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    ptr_d      = ptr_q;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    mod_pend_d = mod_pend_q;
    load_amt   = 1'b0;
    ram_req    = '{re: 1'b0, we: 1'b0, addr: {key_q, ptr_q}};
    ram_wdata  = '0;
    acc_ctrl   = '{en: 1'b0, mode: swec_pkg::ACC_CLR};

    case (state_q)
      swec_pkg::S_CLEAR: begin
        ram_req.we     = 1'b1;
        {key_d, ptr_d} = sweep_next;
        if (&{key_q, ptr_q}) begin
          state_d = swec_pkg::S_IDLE;
        end
      end
      swec_pkg::S_IDLE: begin
        if (mod_pend_q) begin
          state_d = swec_pkg::S_MOD;
        end else if (start_i) begin
          case (op_i)
            swec_pkg::OP_ADD, swec_pkg::OP_SUB: begin
              op_d     = swec_pkg::op_e'(op_i);
              key_d    = key_i;
              ptr_d    = cur_q;
              load_amt = 1'b1;
              status_d = key_bad;
              if (key_bad) begin
                acc_ctrl = '{en: 1'b1, mode: swec_pkg::ACC_CLR};
                state_d  = swec_pkg::S_OUT;
              end else begin
                state_d  = swec_pkg::S_RD;
              end
            end
            swec_pkg::OP_READ: begin
              op_d     = swec_pkg::OP_READ;
              key_d    = key_i;
              ptr_d    = slot_i;
              status_d = key_bad || slot_bad;
              if (key_bad || slot_bad) begin
                acc_ctrl = '{en: 1'b1, mode: swec_pkg::ACC_CLR};
                state_d  = swec_pkg::S_OUT;
              end else begin
                state_d  = swec_pkg::S_RD;
              end
            end
            swec_pkg::OP_SUM: begin
              op_d     = swec_pkg::OP_SUM;
              key_d    = key_i;
              ptr_d    = sum_start;
              cnt_d    = sum_count;
              status_d = key_bad;
              acc_ctrl = '{en: 1'b1, mode: swec_pkg::ACC_CLR};
              if (key_bad || (sum_count == '0)) begin
                state_d = swec_pkg::S_OUT;
              end else begin
                state_d = swec_pkg::S_SUM_RD;
              end
            end
            swec_pkg::OP_TICK: begin
              op_d  = swec_pkg::OP_TICK;
              cur_d = cur_new;
              ptr_d = nxt_slot;
              key_d = '0;
              if (win_eff > swec_pkg::WIN_W'(1)) begin
                state_d = swec_pkg::S_TICK;
              end
            end
            default: begin
              // unused codes: drop the transaction
              state_d = swec_pkg::S_IDLE;
            end
          endcase
        end
      end
      swec_pkg::S_MOD: begin
        if ({1'b0, cur_q} >= win_eff) begin
          cur_d = swec_pkg::SLOT_W'({1'b0, cur_q} - win_eff);
        end else begin
          mod_pend_d = 1'b0;
          state_d    = swec_pkg::S_IDLE;
        end
      end
      swec_pkg::S_RD: begin
        ram_req.re = 1'b1;
        state_d    = swec_pkg::S_RMW;
      end
      swec_pkg::S_RMW: begin
        acc_ctrl.en = 1'b1;
        case (op_q)
          swec_pkg::OP_ADD: acc_ctrl.mode = swec_pkg::ACC_ADD;
          swec_pkg::OP_SUB: acc_ctrl.mode = swec_pkg::ACC_SUB;
          default:          acc_ctrl.mode = swec_pkg::ACC_LOAD;
        endcase
        state_d = swec_pkg::S_OUT;
      end
      swec_pkg::S_SUM_RD: begin
        ram_req.re = 1'b1;
        cnt_d      = cnt_q - swec_pkg::CNT_W'(1);
        ptr_d      = ptr_prev;
        state_d    = swec_pkg::S_SUM_ACC;
      end
      swec_pkg::S_SUM_ACC: begin
        acc_ctrl = '{en: 1'b1, mode: swec_pkg::ACC_ACCUM};
        state_d  = (cnt_q == '0) ? swec_pkg::S_OUT : swec_pkg::S_SUM_RD;
      end
      swec_pkg::S_TICK: begin
        ram_req.we = 1'b1;
        if (key_q == swec_pkg::KEY_W'(swec_pkg::NUM_KEYS - 1)) begin
          state_d = swec_pkg::S_IDLE;
        end else begin
          key_d = key_q + swec_pkg::KEY_W'(1);
        end
      end
      swec_pkg::S_OUT: begin
        // write back the new bucket value of an add or subtract
        if (((op_q == swec_pkg::OP_ADD) || (op_q == swec_pkg::OP_SUB)) && !status_q) begin
          ram_req.we = 1'b1;
          ram_wdata  = acc_val;
        end
        state_d = swec_pkg::S_IDLE;
      end
      default: begin
        state_d = swec_pkg::S_IDLE;
      end
    endcase

    if (window_len_we_i) begin
      mod_pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swec_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= swec_pkg::OP_ADD;
      key_q      <= '0;
      ptr_q      <= '0;
      cur_q      <= '0;
      cnt_q      <= '0;
      status_q   <= 1'b0;
      mod_pend_q <= 1'b0;
      window_q   <= swec_pkg::WinReset;
    end else begin
      op_q       <= op_d;
      key_q      <= key_d;
      ptr_q      <= ptr_d;
      cur_q      <= cur_d;
      cnt_q      <= cnt_d;
      status_q   <= status_d;
      mod_pend_q <= mod_pend_d;
      if (window_len_we_i) begin
        window_q <= window_len_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_amt) begin
      amt_q <= amount_i;
    end
  end

  swec_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  swec_acc u_acc (
    .clk_i    (clk_i),
    .ctrl_i   (acc_ctrl),
    .rdata_i  (ram_rdata),
    .amount_i (amt_q),
    .acc_o    (acc_val)
  );

  assign busy_o         = (state_q != swec_pkg::S_IDLE) || mod_pend_q;
  assign done_o         = (state_q == swec_pkg::S_OUT);
  assign result_value_o = $signed(acc_val);
  assign status_o       = status_q;

  `SWEC_ASSERT(a_one_result, done_o |=> !done_o, "result strobe held for more than one cycle")
  `SWEC_ASSERT_IMPL(a_cur_in_window, (state_q == swec_pkg::S_IDLE) && !mod_pend_q,
                    {1'b0, cur_q} < win_eff, "current slot outside the window while idle")
  `SWEC_ASSERT_IMPL(a_err_zero, done_o && status_o, result_value_o == '0,
                    "out-of-range transaction returned a non-zero value")
  `SWEC_ASSERT_IMPL(a_write_states, ram_req.we,
                    (state_q == swec_pkg::S_CLEAR) || (state_q == swec_pkg::S_TICK) ||
                    (state_q == swec_pkg::S_OUT), "store written outside a write state")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window event counter top level.
// Depends on swec_pkg and sliding_window_event_counter_top; keeps a mirror of the buckets.

module testbench;
  import swec_pkg::*;

  localparam int         SETTLE_CYCLES = 40;   // longer than a tick, the slowest silent op
  localparam logic [2:0] OP_SPARE      = 3'd5; // first of the unused op codes

  typedef struct {
    bit                is_cfg;
    logic [2:0]        op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] amount;
    logic [CNT_W-1:0]  duration;
    logic [SLOT_W-1:0] slot;
    logic [WIN_W-1:0]  win;
  } counter_txn_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              status;
  } counter_res_t;

  logic                     clk_i              = 1'b0;
  logic                     rst_ni             = 1'b0;
  logic                     start_i            = 1'b0;
  logic [2:0]               op_i               = '0;
  logic [KEY_W-1:0]         key_i              = '0;
  logic signed [DATA_W-1:0] amount_i           = '0;
  logic [CNT_W-1:0]         duration_i         = '0;
  logic [SLOT_W-1:0]        slot_i             = '0;
  logic                     window_len_we_i    = 1'b0;
  logic [WIN_W-1:0]         window_len_wdata_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic                     status_o;

  counter_txn_t      pending_ops[$];
  counter_res_t      want_results[$];
  counter_txn_t      held_op;
  counter_res_t      oldest;
  logic [DATA_W-1:0] bucket_mirror [NUM_KEYS*MAX_WINDOW];
  int                slot_mirror;
  logic [WIN_W-1:0]  window_mirror;
  int                gap_left;
  int                burst_left;
  int                quiet_cnt;
  int                errors = 0;
  logic              nx_start;
  logic              nx_we;

  sliding_window_event_counter_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .op_i               (op_i),
    .key_i              (key_i),
    .amount_i           (amount_i),
    .duration_i         (duration_i),
    .slot_i             (slot_i),
    .window_len_we_i    (window_len_we_i),
    .window_len_wdata_i (window_len_wdata_i),
    .done_o             (done_o),
    .result_value_o     (result_value_o),
    .status_o           (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int eff_window(logic [WIN_W-1:0] reg_val);
    if (reg_val == 0) return 1;
    if (reg_val > MAX_WINDOW) return MAX_WINDOW;
    return int'(reg_val);
  endfunction

  // Work out the result of one accepted transaction and advance the mirror.
  task automatic apply_counter_op(input counter_txn_t t);
    int                w;
    int                cur;
    int                cnt;
    int                idx;
    counter_res_t      res;
    w   = eff_window(window_mirror);
    cur = slot_mirror % w;
    res = '{value: '0, status: 1'b0};
    if (t.op == OP_TICK) begin
      cur         = (cur + 1) % w;
      slot_mirror = cur;
      if (w > 1) begin
        for (int k = 0; k < NUM_KEYS; k++) bucket_mirror[k*MAX_WINDOW + (cur + 1) % w] = '0;
      end
      return;
    end
    if (t.op > OP_READ) return;
    idx = int'(t.key) * MAX_WINDOW + cur;
    if (t.key >= NUM_KEYS) begin
      res.status = 1'b1;
    end else begin
      case (t.op)
        OP_ADD: begin
          bucket_mirror[idx] = bucket_mirror[idx] + t.amount;
          res.value = bucket_mirror[idx];
        end
        OP_SUB: begin
          bucket_mirror[idx] = bucket_mirror[idx] - t.amount;
          res.value = bucket_mirror[idx];
        end
        OP_SUM: begin
          // Walk back from the newest completed bucket.
          cnt = (t.duration > w) ? w : int'(t.duration);
          for (int n = 0; n < cnt; n++) begin
            res.value = res.value + bucket_mirror[int'(t.key)*MAX_WINDOW + (cur + w - 1 - n) % w];
          end
        end
        default: begin
          if (t.slot >= w) res.status = 1'b1;
          else res.value = bucket_mirror[int'(t.key)*MAX_WINDOW + int'(t.slot)];
        end
      endcase
    end
    want_results.push_back(res);
  endtask

  function automatic logic [DATA_W-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0:       return 64'h7fff_ffff_ffff_ffff;
      1:       return 64'h8000_0000_0000_0000;
      2:       return {{56{1'b1}}, 8'($urandom)};
      3:       return 64'($urandom_range(0, 1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_op(input logic [2:0] op, input int key, input logic [DATA_W-1:0] amt,
                         input int dur, input int slot);
    counter_txn_t t;
    t          = '{default: '0};
    t.op       = op;
    t.key      = KEY_W'(key);
    t.amount   = amt;
    t.duration = CNT_W'(dur);
    t.slot     = SLOT_W'(slot);
    pending_ops.push_back(t);
  endtask

  task automatic push_window(input int win);
    counter_txn_t t;
    t        = '{default: '0};
    t.is_cfg = 1'b1;
    t.win    = WIN_W'(win);
    pending_ops.push_back(t);
  endtask

  task automatic push_random(input int w);
    counter_txn_t t;
    int           r;
    t = '{default: '0};
    r = $urandom_range(0, 99);
    if (r < 35)      t.op = OP_ADD;
    else if (r < 50) t.op = OP_SUB;
    else if (r < 68) t.op = OP_TICK;
    else if (r < 83) t.op = OP_SUM;
    else if (r < 97) t.op = OP_READ;
    else             t.op = OP_SPARE + 3'($urandom_range(0, 2));
    // Favour a few keys so that buckets build up.
    t.key      = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom);
    t.amount   = pick_amount();
    t.duration = ($urandom_range(0, 3) != 0) ? CNT_W'($urandom_range(0, w + 1))
                                              : CNT_W'($urandom);
    t.slot     = ($urandom_range(0, 3) != 0) ? SLOT_W'($urandom_range(0, w - 1))
                                              : SLOT_W'($urandom);
    pending_ops.push_back(t);
  endtask

  // Driver: one transaction or one window write at a time, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i            <= 1'b0;
      window_len_we_i    <= 1'b0;
      window_len_wdata_i <= '0;
      op_i               <= '0;
      key_i              <= '0;
      amount_i           <= '0;
      duration_i         <= '0;
      slot_i             <= '0;
      foreach (bucket_mirror[i]) bucket_mirror[i] = '0;
      slot_mirror   = 0;
      window_mirror = WinReset;
      gap_left      = 0;
      burst_left    = 0;
      quiet_cnt     = 0;
    end else begin
      nx_start = start_i;
      nx_we    = 1'b0;
      if (start_i && !busy_o) begin
        apply_counter_op(held_op);
        nx_start  = 1'b0;
        quiet_cnt = 0;
      end else if (!start_i) begin
        quiet_cnt++;
      end
      if (!nx_start && pending_ops.size() != 0) begin
        if (pending_ops[0].is_cfg) begin
          // Hold the write until the block has drained and gone quiet.
          if (want_results.size() == 0 && quiet_cnt >= SETTLE_CYCLES && !busy_o &&
              !window_len_we_i) begin
            nx_we              = 1'b1;
            window_len_wdata_i <= pending_ops[0].win;
            window_mirror      = pending_ops[0].win;
            slot_mirror        = slot_mirror % eff_window(window_mirror);
            quiet_cnt          = 0;
            void'(pending_ops.pop_front());
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          held_op    = pending_ops.pop_front();
          op_i       <= held_op.op;
          key_i      <= held_op.key;
          amount_i   <= held_op.amount;
          duration_i <= held_op.duration;
          slot_i     <= held_op.slot;
          nx_start   = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 30);
          end
        end
      end
      start_i         <= nx_start;
      window_len_we_i <= nx_we;
    end
  end

  // Monitor: every strobed result must match the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (want_results.size() == 0) begin
        $display("%0t: unexpected result, got value %h status %b", $time,
                 result_value_o, status_o);
        errors++;
      end else begin
        oldest = want_results.pop_front();
        if (result_value_o !== oldest.value) begin
          $display("%0t: result_value mismatch, expected %h got %h", $time,
                   oldest.value, result_value_o);
          errors++;
        end
        if (status_o !== oldest.status) begin
          $display("%0t: status mismatch, expected %b got %b", $time, oldest.status, status_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int win_plan[8];
    win_plan = '{7, 1, 0, 64, 127, 2, 33, 60};

    // Directed part, at the reset window of 60.
    push_op(OP_ADD, 0, 64'h7fff_ffff_ffff_ffff, 0, 0);
    push_op(OP_ADD, 0, 64'h1, 0, 0);                      // wrap to the most negative value
    push_op(OP_SUB, 15, 64'h8000_0000_0000_0000, 0, 0);
    push_op(OP_SUB, 15, 64'h1, 0, 0);
    push_op(OP_ADD, 9, '1, 0, 0);
    push_op(OP_READ, 0, '0, 0, 0);
    push_op(OP_READ, 15, '0, 0, 59);
    push_op(OP_READ, 0, '0, 0, 60);                       // slot beyond the window
    push_op(OP_READ, 0, '0, 0, 63);
    push_op(OP_SUM, 0, '0, 0, 0);                         // empty sum
    push_op(OP_SUM, 15, '0, 60, 0);
    push_op(OP_TICK, 0, '0, 0, 0);
    push_op(OP_SUM, 0, '0, 1, 0);
    push_op(OP_SUM, 15, '0, 64, 0);
    push_op(OP_SUM, 15, '0, 127, 0);                      // duration clamped to the window
    push_op(OP_ADD, 0, 64'h5, 0, 0);
    push_op(OP_TICK, 0, '0, 0, 0);
    push_op(OP_READ, 0, '0, 0, 1);
    push_op(OP_SUM, 0, '0, 2, 0);
    push_op(OP_READ, 10, '0, 42, 42);
    push_op(OP_SPARE, 15, '1, 127, 63);
    push_op(OP_SPARE + 3'd1, 15, '1, 127, 63);
    push_op(OP_SPARE + 3'd2, 15, '1, 127, 63);
    push_op(OP_READ, 5, '0, 85, 21);

    foreach (win_plan[p]) begin
      push_window(win_plan[p]);
      repeat (85) push_random(eff_window(WIN_W'(win_plan[p])));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample away from the active edge so that the driver's updates have settled.
    while (pending_ops.size() != 0 || start_i || window_len_we_i || busy_o ||
           want_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
